// ===== rtl/core/arp_pkg.sv =====
// Shared types and constants for the arpeggio step sequencer core.
// No dependencies; used by the core top level and by the bench.
package arp_pkg;

   // Default sizes handed to the top-level parameters
   localparam int MAX_NOTES_DEF     = 16;
   localparam int PATTERN_STEPS_DEF = 16;

   // Rhythm pattern holds one bit per position
   localparam int RHYTHM_BITS = 16;
   // Compare width for pattern positions (positions stay below 32)
   localparam int POS_CMP_W   = 6;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCTAVE_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RHYTHM_PATTERN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_STEP = 3'd4;

   // Direction modes (codes 6 and 7 run as up)
   localparam logic [2:0] MODE_UP      = 3'd0;
   localparam logic [2:0] MODE_DOWN    = 3'd1;
   localparam logic [2:0] MODE_UP_DOWN = 3'd2;
   localparam logic [2:0] MODE_RANDOM  = 3'd3;
   localparam logic [2:0] MODE_PLAYED  = 3'd4;
   localparam logic [2:0] MODE_CHORD   = 3'd5;

   // Input word
   typedef struct packed {
      logic       action;
      logic [4:0] held_notes;
      logic [7:0] rand_bits;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic       fire;
      logic       chord_all;
      logic       played_order;
      logic [3:0] note_index;
      logic [1:0] octave_offset;
   } rsp_word_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CALC = 5'b00010,
      ST_ADV  = 5'b00100,
      ST_MOD  = 5'b01000,
      ST_OUT  = 5'b10000
   } seq_state_type;

endpackage

// ===== rtl/core/arp_mod_unit.sv =====
// Shared remainder step: one bit of a restoring division per cycle.
// Depends on nothing; the sequencer in the top level drives it.
module arp_mod_unit (
   input  logic [4:0] rem,
   input  logic       shift_bit,
   input  logic [4:0] divisor,
   output logic [4:0] rem_next
);

   logic [5:0] trial;
   logic [5:0] div_ext;
   logic [5:0] diff;

   // shift the next dividend bit in, subtract when it fits
   assign trial    = {rem, shift_bit};
   assign div_ext  = {1'b0, divisor};
   assign diff     = trial - div_ext;
   assign rem_next = (trial >= div_ext) ? diff[4:0] : trial[4:0];

endmodule

// ===== rtl/core/arp_advance.sv =====
// One step of the note/octave walk: up or down, wrap, octave move, reversal.
// Depends on nothing beyond its ports; the top level applies it once or twice.
module arp_advance #(
   parameter int MAX_NOTES = 16
) (
   input  logic [$clog2(MAX_NOTES)-1:0] note_pos,
   input  logic [1:0]                   oct_pos,
   input  logic                         going_down,
   input  logic [4:0]                   note_count,
   input  logic [2:0]                   oct_count,
   input  logic                         up_down,
   input  logic                         second_pass,
   output logic [$clog2(MAX_NOTES)-1:0] note_next,
   output logic [1:0]                   oct_next,
   output logic                         going_down_next,
   output logic                         repeat_step
);

   localparam int NOTE_W = $clog2(MAX_NOTES);

   logic [5:0]        note_ext;
   logic [5:0]        note_step;
   logic              note_wrap;
   logic [NOTE_W-1:0] note_wrapped;
   logic [2:0]        oct_step;
   logic              oct_out;
   logic              dir;
   logic [4:0]        last_note;
   logic [2:0]        last_oct;

   assign note_ext  = 6'(note_pos);
   assign last_note = note_count - 5'd1;
   assign last_oct  = oct_count - 3'd1;

   always_comb begin
      // note position moves one place; falling below zero is checked first
      note_step = going_down ? (note_ext - 6'd1) : (note_ext + 6'd1);
      if (going_down && (note_ext == 6'd0)) begin
         note_wrap    = 1'b1;
         note_wrapped = NOTE_W'(last_note);
      end else if (note_step >= 6'(note_count)) begin
         note_wrap    = 1'b1;
         note_wrapped = '0;
      end else begin
         note_wrap    = 1'b0;
         note_wrapped = NOTE_W'(note_step);
      end

      // octave moves only on a note wrap
      oct_step = going_down ? (3'(oct_pos) - 3'd1) : (3'(oct_pos) + 3'd1);
      oct_out  = (going_down && (oct_pos == 2'd0)) || (oct_step >= oct_count);

      note_next       = note_wrapped;
      oct_next        = oct_pos;
      going_down_next = going_down;
      repeat_step     = 1'b0;
      dir             = going_down;

      if (note_wrap) begin
         if (!oct_out) begin
            oct_next = oct_step[1:0];
         end else begin
            // end of a pass: up-down reverses, then restart the pass
            dir             = up_down ? !going_down : going_down;
            going_down_next = dir;
            note_next       = dir ? NOTE_W'(last_note) : '0;
            oct_next        = dir ? last_oct[1:0] : 2'd0;
            repeat_step     = up_down && ((note_count > 5'd1) || (oct_count > 3'd1))
                              && !second_pass;
         end
      end
   end

endmodule

// ===== rtl/core/arpeggio_step_sequencer_core.sv =====
// Arpeggio step sequencer core: prescaler, rhythm pattern and step sequencer.
// Depends on arp_pkg, arp_advance and arp_mod_unit.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_ready  arp_pkg::req_word_type
//   rsp_     out        rsp_valid / rsp_ready  arp_pkg::rsp_word_type
//   csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// A word is worked in the calculate state; the output state then loads the
// result once the output register is free. Starts, non-steps, chords and the
// first step after a start skip the advance state; random mode runs the shared
// unit instead, a modulo by held notes and then one by octaves.
// req_ready is high only in idle; a result waiting in the output register does
// not block acceptance, only the load of the next result.
// Reset is synchronous; csr_ready is always high.
module arpeggio_step_sequencer_core #(
   parameter int MAX_NOTES     = arp_pkg::MAX_NOTES_DEF,
   parameter int PATTERN_STEPS = arp_pkg::PATTERN_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  arp_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output arp_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [arp_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int NOTE_W = $clog2(MAX_NOTES);
   localparam int PP_W   = $clog2(PATTERN_STEPS);

   // configuration registers
   logic [2:0]  mode_ff;
   logic [2:0]  octave_count_ff;
   logic [15:0] rhythm_ff;
   logic [4:0]  pattern_length_ff;
   logic [6:0]  ticks_per_step_ff;

   // sequencer state
   arp_pkg::seq_state_type state_ff, state_in;
   logic [6:0]        tick_count_ff, tick_count_in;
   logic [PP_W-1:0]   pattern_pos_ff, pattern_pos_in;
   logic              going_down_ff, going_down_in;
   logic [1:0]        oct_pos_ff, oct_pos_in;
   logic [NOTE_W-1:0] note_pos_ff, note_pos_in;
   logic              awaiting_ff, awaiting_in;

   // latched input word and work registers
   logic              action_ff;
   logic [4:0]        notes_ff;
   logic [7:0]        rnd_ff;
   logic              fire_ff, fire_in;
   logic              chord_ff, chord_in;
   logic              depth_ff, depth_in;
   logic [2:0]        mod_cnt_ff, mod_cnt_in;
   logic [4:0]        rem_ff, rem_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   arp_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic       rsp_load;
   logic [4:0] held_clamped;
   logic [2:0] octs;
   logic [2:0] last_oct;
   logic [4:0] last_note;
   logic [6:0] tick_inc;
   logic [PP_W:0] pp_inc;
   logic       pp_wrap;
   logic       plays;
   logic       active;

   // shared-unit and advance-step wiring
   logic [4:0]        mod_rem;
   logic              mod_bit;
   logic [4:0]        mod_div;
   logic [4:0]        mod_rem_next;
   logic [NOTE_W-1:0] adv_note;
   logic [1:0]        adv_oct;
   logic              adv_down;
   logic              adv_repeat;

   assign req_ready = (state_ff == arp_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // held notes and octave count limited to their ranges
   assign held_clamped = (int'(req_data.held_notes) > MAX_NOTES) ?
                         5'(MAX_NOTES) : req_data.held_notes;
   assign octs = (octave_count_ff == 3'd0) ? 3'd1 :
                 (octave_count_ff > 3'd4)  ? 3'd4 : octave_count_ff;
   assign last_oct  = octs - 3'd1;
   assign last_note = notes_ff - 5'd1;

   // prescaler and pattern position
   assign tick_inc = tick_count_ff + 7'd1;
   assign pp_inc   = {1'b0, pattern_pos_ff} + (PP_W+1)'(1);
   assign pp_wrap  = (arp_pkg::POS_CMP_W'(pp_inc) == arp_pkg::POS_CMP_W'(pattern_length_ff))
                     || (pp_inc >= (PP_W+1)'(PATTERN_STEPS));
   assign plays    = (arp_pkg::POS_CMP_W'(pattern_pos_ff) <
                      arp_pkg::POS_CMP_W'(arp_pkg::RHYTHM_BITS))
                     && rhythm_ff[4'(pattern_pos_ff)];

   // remainder unit: note nibble by held notes, then octave nibble by octaves
   assign mod_rem = (mod_cnt_ff[1:0] == 2'd0) ? 5'd0 : rem_ff;
   assign mod_bit = rnd_ff[~mod_cnt_ff];
   assign mod_div = mod_cnt_ff[2] ? {2'b00, octs} : notes_ff;

   arp_mod_unit u_mod (
      .rem       (mod_rem),
      .shift_bit (mod_bit),
      .divisor   (mod_div),
      .rem_next  (mod_rem_next)
   );

   arp_advance #(
      .MAX_NOTES (MAX_NOTES)
   ) u_adv (
      .note_pos        (note_pos_ff),
      .oct_pos         (oct_pos_ff),
      .going_down      (going_down_ff),
      .note_count      (notes_ff),
      .oct_count       (octs),
      .up_down         (mode_ff == arp_pkg::MODE_UP_DOWN),
      .second_pass     (depth_ff),
      .note_next       (adv_note),
      .oct_next        (adv_oct),
      .going_down_next (adv_down),
      .repeat_step     (adv_repeat)
   );

   // result word built from the final positions
   assign active   = fire_ff && !chord_ff;
   assign rsp_load = (state_ff == arp_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_data_in.fire          = fire_ff;
      rsp_data_in.chord_all     = chord_ff;
      rsp_data_in.played_order  = active && (mode_ff == arp_pkg::MODE_PLAYED);
      rsp_data_in.note_index    = active ? 4'(note_pos_ff) : 4'd0;
      rsp_data_in.octave_offset = active ? oct_pos_ff : 2'd0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      tick_count_in  = tick_count_ff;
      pattern_pos_in = pattern_pos_ff;
      going_down_in  = going_down_ff;
      oct_pos_in     = oct_pos_ff;
      note_pos_in    = note_pos_ff;
      awaiting_in    = awaiting_ff;
      fire_in        = fire_ff;
      chord_in       = chord_ff;
      depth_in       = depth_ff;
      mod_cnt_in     = mod_cnt_ff;
      rem_in         = rem_ff;

      case (state_ff)
         arp_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = arp_pkg::ST_CALC;
            end
         end

         arp_pkg::ST_CALC: begin
            fire_in  = 1'b0;
            chord_in = 1'b0;
            state_in = arp_pkg::ST_OUT;
            if (action_ff) begin
               // start: next tick makes a step
               pattern_pos_in = '0;
               tick_count_in  = ticks_per_step_ff - 7'd1;
               going_down_in  = (mode_ff == arp_pkg::MODE_DOWN);
               awaiting_in    = 1'b1;
            end else if (tick_inc < ticks_per_step_ff) begin
               tick_count_in = tick_inc;
            end else begin
               tick_count_in  = 7'd0;
               pattern_pos_in = pp_wrap ? '0 : PP_W'(pp_inc);
               if ((notes_ff != 5'd0) && plays) begin
                  fire_in = 1'b1;
                  if (mode_ff == arp_pkg::MODE_CHORD) begin
                     chord_in = 1'b1;
                  end else if (awaiting_ff) begin
                     // first step begins the pass
                     awaiting_in = 1'b0;
                     note_pos_in = going_down_ff ? NOTE_W'(last_note) : '0;
                     oct_pos_in  = going_down_ff ? last_oct[1:0] : 2'd0;
                  end else if (mode_ff == arp_pkg::MODE_RANDOM) begin
                     mod_cnt_in = 3'd0;
                     state_in   = arp_pkg::ST_MOD;
                  end else begin
                     depth_in = 1'b0;
                     state_in = arp_pkg::ST_ADV;
                  end
               end
            end
         end

         arp_pkg::ST_ADV: begin
            note_pos_in   = adv_note;
            oct_pos_in    = adv_oct;
            going_down_in = adv_down;
            if (adv_repeat) begin
               depth_in = 1'b1;
            end else begin
               state_in = arp_pkg::ST_OUT;
            end
         end

         arp_pkg::ST_MOD: begin
            rem_in     = mod_rem_next;
            mod_cnt_in = mod_cnt_ff + 3'd1;
            if (mod_cnt_ff == 3'd3) begin
               note_pos_in = NOTE_W'(mod_rem_next);
            end
            if (mod_cnt_ff == 3'd7) begin
               oct_pos_in = mod_rem_next[1:0];
               state_in   = arp_pkg::ST_OUT;
            end
         end

         arp_pkg::ST_OUT: begin
            if (rsp_load) begin
               state_in = arp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = arp_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= arp_pkg::ST_IDLE;
         tick_count_ff     <= 7'd0;
         pattern_pos_ff    <= '0;
         going_down_ff     <= 1'b0;
         oct_pos_ff        <= 2'd0;
         note_pos_ff       <= '0;
         awaiting_ff       <= 1'b1;
         rsp_valid_ff      <= 1'b0;
         mode_ff           <= arp_pkg::MODE_UP;
         octave_count_ff   <= 3'd1;
         rhythm_ff         <= 16'hffff;
         pattern_length_ff <= 5'd16;
         ticks_per_step_ff <= 7'd6;
      end else begin
         state_ff       <= state_in;
         tick_count_ff  <= tick_count_in;
         pattern_pos_ff <= pattern_pos_in;
         going_down_ff  <= going_down_in;
         oct_pos_ff     <= oct_pos_in;
         note_pos_ff    <= note_pos_in;
         awaiting_ff    <= awaiting_in;
         rsp_valid_ff   <= rsp_valid_in;
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               arp_pkg::CSR_DIRECTION_MODE: mode_ff           <= csr_data[2:0];
               arp_pkg::CSR_OCTAVE_COUNT:   octave_count_ff   <= csr_data[2:0];
               arp_pkg::CSR_RHYTHM_PATTERN: rhythm_ff         <= csr_data[15:0];
               arp_pkg::CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[4:0];
               arp_pkg::CSR_TICKS_PER_STEP: ticks_per_step_ff <= csr_data[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_data.action;
         notes_ff  <= held_clamped;
         rnd_ff    <= req_data.rand_bits;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      fire_ff    <= fire_in;
      chord_ff   <= chord_in;
      depth_ff   <= depth_in;
      mod_cnt_ff <= mod_cnt_in;
      rem_ff     <= rem_in;
   end

endmodule

// ===== bench/arp_checker.sv =====
// Result checker for arpeggio_step_sequencer_core: tracks register writes,
// predicts one result word per accepted input word and compares them in order.
// Depends on arp_pkg for the word types, register indexes and mode codes.
module arp_checker import arp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_word_type           req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Register copy
   logic [2:0]  cfg_mode    = MODE_UP;
   logic [2:0]  cfg_octaves = 3'd1;
   logic [15:0] cfg_pattern = 16'hFFFF;
   logic [4:0]  cfg_length  = 5'd16;
   logic [6:0]  cfg_ticks   = 7'd6;

   // Sequencer state
   logic [6:0] tick_ctr      = '0;
   int         pat_pos       = 0;
   bit         descending    = 1'b0;
   bit         first_pending = 1'b1;
   int         oct_pos       = 0;
   int         note_pos      = 0;

   rsp_word_type pending_plays[$];
   int           mismatches   = 0;
   int           results_seen = 0;

   // Start of a pass: bottom of the range going up, top going down
   function automatic void begin_pass(input int n, input int octs);
      if (!descending) begin
         oct_pos  = 0;
         note_pos = 0;
      end else begin
         note_pos = n - 1;
         oct_pos  = octs - 1;
      end
   endfunction

   // One move of the note/octave walk; returns 1 when an up-down reversal
   // needs a second move so the end note is not repeated
   function automatic bit walk_once(input int n, input int octs,
                                    input logic [7:0] rnd, input int depth);
      int dir;
      if (first_pending) begin
         first_pending = 1'b0;
         begin_pass(n, octs);
         return 1'b0;
      end
      if (cfg_mode == MODE_RANDOM) begin
         oct_pos  = int'(rnd[3:0]) % octs;
         note_pos = int'(rnd[7:4]) % n;
         return 1'b0;
      end
      dir = descending ? -1 : 1;
      note_pos += dir;
      if (note_pos >= n) note_pos = 0;
      else if (note_pos < 0) note_pos = n - 1;
      else return 1'b0;
      oct_pos += dir;
      if (oct_pos < octs && oct_pos >= 0) return 1'b0;
      if (cfg_mode == MODE_UP_DOWN) begin
         descending = !descending;
         begin_pass(n, octs);
         return (n > 1 || octs > 1) && depth == 0;
      end
      begin_pass(n, octs);
      return 1'b0;
   endfunction

   // Expected result word for one input word; updates the sequencer state
   function automatic rsp_word_type next_play(input req_word_type w);
      rsp_word_type r;
      int           n;
      int           octs;
      bit           plays;
      r    = '0;
      n    = (int'(w.held_notes) > MAX_NOTES_DEF) ? MAX_NOTES_DEF : int'(w.held_notes);
      octs = (cfg_octaves < 3'd1) ? 1 : (cfg_octaves > 3'd4) ? 4 : int'(cfg_octaves);
      if (w.action) begin
         pat_pos       = 0;
         tick_ctr      = cfg_ticks - 7'd1;
         descending    = (cfg_mode == MODE_DOWN);
         first_pending = 1'b1;
         return r;
      end
      tick_ctr = tick_ctr + 7'd1;
      if (tick_ctr < cfg_ticks) return r;
      tick_ctr = '0;
      plays = (pat_pos < RHYTHM_BITS) ? cfg_pattern[pat_pos] : 1'b0;
      if (n > 0 && plays) begin
         r.fire = 1'b1;
         if (cfg_mode == MODE_CHORD) begin
            r.chord_all = 1'b1;
         end else begin
            if (walk_once(n, octs, w.rand_bits, 0))
               void'(walk_once(n, octs, w.rand_bits, 1));
            r.played_order  = (cfg_mode == MODE_PLAYED);
            r.note_index    = note_pos[3:0];
            r.octave_offset = oct_pos[1:0];
         end
      end
      pat_pos++;
      if (pat_pos == int'(cfg_length) || pat_pos >= PATTERN_STEPS_DEF) pat_pos = 0;
      return r;
   endfunction

   // Print one line per mismatch and count it
   task automatic note_failure(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         note_failure($sformatf("word %0d %s: got %0h want %0h",
                                results_seen, field, got, want));
   endtask

   // Watch all three channels
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         cfg_mode      = MODE_UP;
         cfg_octaves   = 3'd1;
         cfg_pattern   = 16'hFFFF;
         cfg_length    = 5'd16;
         cfg_ticks     = 7'd6;
         tick_ctr      = '0;
         pat_pos       = 0;
         descending    = 1'b0;
         first_pending = 1'b1;
         oct_pos       = 0;
         note_pos      = 0;
         pending_plays.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIRECTION_MODE: cfg_mode    = csr_data[2:0];
               CSR_OCTAVE_COUNT:   cfg_octaves = csr_data[2:0];
               CSR_RHYTHM_PATTERN: cfg_pattern = csr_data[15:0];
               CSR_PATTERN_LENGTH: cfg_length  = csr_data[4:0];
               CSR_TICKS_PER_STEP: cfg_ticks   = csr_data[6:0];
               default: ;
            endcase
         end
         // results leave before a new word can be predicted
         if (rsp_valid && rsp_ready) begin
            if (pending_plays.size() == 0) begin
               note_failure($sformatf("word %0d arrived with nothing expected",
                                      results_seen));
            end else begin
               want = pending_plays.pop_front();
               check_field("fire", 8'(rsp_data.fire), 8'(want.fire));
               check_field("chord_all", 8'(rsp_data.chord_all), 8'(want.chord_all));
               check_field("played_order", 8'(rsp_data.played_order),
                           8'(want.played_order));
               check_field("note_index", 8'(rsp_data.note_index), 8'(want.note_index));
               check_field("octave_offset", 8'(rsp_data.octave_offset),
                           8'(want.octave_offset));
            end
            results_seen++;
         end
         if (req_valid && req_ready) pending_plays.push_back(next_play(req_data));
      end
      pending_count <= pending_plays.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== bench/tb.sv =====
// Top of the arpeggio_step_sequencer_core bench: clock, reset, register
// phases, directed and random tick/start words, bursty sender, stalling receiver.
// Depends on arp_pkg, the core RTL and arp_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import arp_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_PAD     = 16;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 54;

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_START = 1'b1;

   // unmapped register index and unused mode code
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE  = 3'd7;
   localparam logic [2:0]             MODE_SPARE = 3'd6;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   int                     fail_count;
   int                     pending_count;
   int                     cycle_count;

   // sender burst state
   int burst_left = 0;

   // receiver state
   int          hold_left      = 0;
   bit          long_hold_go   = 1'b0;
   bit          long_hold_used = 1'b0;
   logic [15:0] ready_bits     = '1;
   int          ready_ptr      = 0;
   int          pattern_left   = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   arpeggio_step_sequencer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   arp_checker play_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Receiver: rotating ready pattern, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_hold_go && !long_hold_used) begin
         long_hold_used <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_ready      <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            ready_bits   <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
            pattern_left <= $urandom_range(16, 160);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         rsp_ready <= ready_bits[ready_ptr];
         ready_ptr <= (ready_ptr + 1) % 16;
      end
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL arpeggio_step_sequencer_core");
      $finish;
   end

   // Offer one word and wait for it to be taken; bursts end in a random gap
   task automatic send_word(input logic action, input logic [4:0] held,
                            input logic [7:0] rnd);
      req_word_type w;
      int           gap;
      w.action      = action;
      w.held_notes  = held;
      w.rand_bits   = rnd;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait until every expected word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Random junk in the data bits above a register's width
   function automatic int junk_above(input int width);
      return ($urandom_range(0, 3) == 0) ? ((int'($urandom) << width) & 'hFFFF) : 0;
   endfunction

   task automatic configure(input int mode, input int octs, input int pattern,
                            input int length, input int ticks);
      write_reg(CSR_DIRECTION_MODE, mode | junk_above(3));
      write_reg(CSR_OCTAVE_COUNT, octs | junk_above(3));
      write_reg(CSR_RHYTHM_PATTERN, pattern);
      write_reg(CSR_PATTERN_LENGTH, length | junk_above(5));
      write_reg(CSR_TICKS_PER_STEP, ticks | junk_above(7));
      csr_valid <= 1'b0;
   endtask

   // Held-note count: mostly small, sometimes none or beyond the store size
   function automatic logic [4:0] pick_held();
      case ($urandom_range(0, 11))
         0:       return 5'd0;
         1:       return 5'($urandom_range(17, 31));
         2, 3, 4: return 5'($urandom_range(5, 16));
         default: return 5'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      int         cnt;
      int         mode;
      int         octs;
      int         pattern;
      int         length;
      int         ticks;
      logic [4:0] held;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: prescaler of 6, first step starts at note 0
      repeat (5) send_word(ACT_TICK, 5'd31, 8'hFF);
      send_word(ACT_TICK, 5'd3, 8'h00);
      drain_results();

      // Down, four octaves, zero prescaler, stale note position, no notes
      write_reg(CSR_SPARE, 'hFFFF);
      configure(int'(MODE_DOWN), 4, 'hFFFF, 16, 0);
      send_word(ACT_START, 5'd0, 8'h00);
      send_word(ACT_TICK, 5'd16, 8'h5A);
      send_word(ACT_TICK, 5'd16, 8'hA5);
      send_word(ACT_TICK, 5'd2, 8'h00);
      send_word(ACT_TICK, 5'd0, 8'hFF);
      drain_results();

      // Up-down with single note and two notes, length-one pattern
      configure(int'(MODE_UP_DOWN), 1, 'hFFFF, 1, 1);
      send_word(ACT_START, 5'd1, 8'h00);
      send_word(ACT_TICK, 5'd1, 8'h00);
      send_word(ACT_TICK, 5'd1, 8'h00);
      send_word(ACT_TICK, 5'd2, 8'h00);
      send_word(ACT_TICK, 5'd2, 8'h00);
      send_word(ACT_TICK, 5'd2, 8'h00);
      drain_results();

      // Random mode, octave count above range, zero pattern length
      configure(int'(MODE_RANDOM), 7, 'hFFFF, 0, 1);
      send_word(ACT_START, 5'd31, 8'hFF);
      send_word(ACT_TICK, 5'd31, 8'hFF);
      send_word(ACT_TICK, 5'd31, 8'hFF);
      send_word(ACT_TICK, 5'd5, 8'h00);
      drain_results();

      // As played, octave count zero, long length, largest prescaler
      configure(int'(MODE_PLAYED), 0, 'h8001, 31, 127);
      send_word(ACT_START, 5'd4, 8'h00);
      send_word(ACT_TICK, 5'd4, 8'h00);
      drain_results();

      // Chord, then an unused mode code
      configure(int'(MODE_CHORD), 2, 'hFFFF, 16, 1);
      send_word(ACT_TICK, 5'd8, 8'h00);
      send_word(ACT_TICK, 5'd0, 8'h00);
      drain_results();
      configure(int'(MODE_SPARE), 2, 'hFFFF, 16, 1);
      send_word(ACT_TICK, 5'd3, 8'h00);

      // Random phases: settings, a start, then mostly ticks
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         mode = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 5);
         case ($urandom_range(0, 7))
            0:       octs = $urandom_range(0, 7);
            default: octs = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 7))
            0:       pattern = 0;
            1:       pattern = 'hFFFF;
            2:       pattern = 1 << $urandom_range(0, 15);
            default: pattern = $urandom & 'hFFFF;
         endcase
         case ($urandom_range(0, 9))
            0:       length = $urandom_range(0, 31);
            1:       length = 16;
            default: length = $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 9))
            0:       ticks = 0;
            1:       ticks = ($urandom_range(0, 1) == 0) ? 96 : 127;
            default: ticks = $urandom_range(1, 4);
         endcase
         configure(mode, octs, pattern, length, ticks);
         if (phase == 1) long_hold_go <= 1'b1;
         held = pick_held();
         send_word(ACT_START, held, 8'($urandom));
         for (cnt = 0; cnt < PHASE_WORDS; cnt++) begin
            if ($urandom_range(0, 9) == 0) held = pick_held();
            // pause mid-phase until the block has emptied
            if (phase == 3 && cnt == PHASE_WORDS / 2) drain_results();
            send_word(($urandom_range(0, 24) == 0) ? ACT_START : ACT_TICK, held,
                      8'($urandom));
         end
      end
      drain_results();

      if (fail_count == 0 && pending_count == 0)
         $display("PASS arpeggio_step_sequencer_core");
      else
         $display("FAIL arpeggio_step_sequencer_core");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/arp_pkg.sv
rtl/core/arp_mod_unit.sv
rtl/core/arp_advance.sv
rtl/core/arpeggio_step_sequencer_core.sv
bench/arp_checker.sv
bench/tb.sv
